// ----- sv/sbus_frame_decoder_top_macros.svh -----
// assertion macros for the sbus frame decoder checker
`ifndef SBUS_FRAME_DECODER_TOP_MACROS_SVH
`define SBUS_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SBFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbfd check failed");

// next-cycle implication, off during reset
`define SBFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbfd check failed");

// next-cycle implication, also checked across reset
`define SBFD_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sbfd reset check failed");

`endif

// ----- sv/sbfd_pkg.sv -----
// shared types and constants of the sbus frame decoder
package sbfd_pkg;

  localparam int FRAME_STORED  = 24;
  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int NUM_CH        = 16;
  localparam int CH_W          = 11;
  localparam int CH_IDX_W      = $clog2(NUM_CH);
  localparam int COUNT_W       = $clog2(FRAME_STORED + 1);
  localparam int FLAG_W        = 4;
  localparam int REG_IDX_W     = 1;
  localparam int REG_W         = 8;

  localparam logic [REG_IDX_W-1:0] REG_HEADER = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_END    = 1'd1;

  typedef enum logic [1:0] {
    ST_CHANNEL = 2'd0,
    ST_ERROR   = 2'd1,
    ST_DESYNC  = 2'd2
  } status_t;

  // one unit of work for the back part
  typedef struct packed {
    status_t                kind;
    logic [PAYLOAD_W-1:0]   payload;
    logic [FLAG_W-1:0]      flags;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_ctrl_t;

endpackage

// ----- sv/sbfd_collect.sv -----
// front part: register file, byte collection and frame check
module sbfd_collect
  import sbfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 command,
  input  logic [7:0]           data_byte,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  input  q_ctrl_t              qs,
  output logic                 job_push,
  output job_t                 job
);

  logic [7:0]         header_byte;
  logic [7:0]         end_byte;
  logic [COUNT_W-1:0] byte_count;
  // shift line: newest byte at position 0, first byte ends at the top
  logic [7:0]         frame [FRAME_STORED];
  logic               accept;
  logic               frame_done;

  assign accept     = push && !qs.full;
  assign frame_done = !command && (byte_count == COUNT_W'(FRAME_STORED));
  assign job_push   = accept && (command || frame_done);

  always_comb begin
    for (int j = 0; j < PAYLOAD_BYTES; j++) begin
      job.payload[8*j +: 8] = frame[PAYLOAD_BYTES - j];
    end
    job.flags = frame[0][FLAG_W-1:0];
    if (command) begin
      job.kind = ST_DESYNC;
    end else if (frame[FRAME_STORED-1] != header_byte || data_byte != end_byte) begin
      job.kind = ST_ERROR;
    end else begin
      job.kind = ST_CHANNEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'h0F;
      end_byte    <= 8'h00;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HEADER: header_byte <= wr_data;
        REG_END:    end_byte    <= wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (command || frame_done) begin
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !command && !frame_done) begin
      frame[0] <= data_byte;
      for (int k = 1; k < FRAME_STORED; k++) begin
        frame[k] <= frame[k-1];
      end
    end
  end

endmodule

// ----- sv/sbfd_jobq.sv -----
// two-entry job queue between front and back
module sbfd_jobq
  import sbfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_push,
  input  job_t    job_in,
  input  logic    job_pop,
  output q_ctrl_t qs,
  output job_t    head
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign qs.full  = (count == 2'd2);
  assign qs.valid = (count != 2'd0);
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (job_push) begin
        wptr <= ~wptr;
      end
      if (job_pop) begin
        rptr <= ~rptr;
      end
      unique case ({job_push, job_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      mem[wptr] <= job_in;
    end
  end

endmodule

// ----- sv/sbfd_emit.sv -----
// back part: channel unpacking into the result register
module sbfd_emit
  import sbfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  q_ctrl_t             qs,
  input  job_t                head,
  output logic                job_pop,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          status,
  output logic [CH_IDX_W-1:0] channel_index,
  output logic [CH_W-1:0]     channel_value,
  output logic                failsafe,
  output logic                link_lost,
  output logic                ch17_flag,
  output logic                ch18_flag,
  output logic                last
);

  logic [CH_IDX_W-1:0] ch;
  logic                out_valid;
  logic                load;
  logic                ch_last;

  assign empty   = !out_valid;
  assign load    = qs.valid && (!out_valid || pop);
  assign ch_last = (ch == CH_IDX_W'(NUM_CH - 1));
  assign job_pop = load && (head.kind != ST_CHANNEL || ch_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ch        <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load && head.kind == ST_CHANNEL) begin
        ch <= ch_last ? '0 : ch + CH_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= head.kind;
      unique case (head.kind)
        ST_CHANNEL: begin
          channel_index <= ch;
          channel_value <= head.payload[CH_W*ch +: CH_W];
          failsafe      <= head.flags[3];
          link_lost     <= head.flags[2];
          ch17_flag     <= head.flags[0];
          ch18_flag     <= head.flags[1];
          last          <= ch_last;
        end
        default: begin
          channel_index <= '0;
          channel_value <= '0;
          failsafe      <= 1'b1;
          link_lost     <= 1'b1;
          ch17_flag     <= 1'b0;
          ch18_flag     <= 1'b0;
          last          <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- sv/sbus_frame_decoder_top.sv -----
// top level of the sbus frame decoder
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | command, data_byte
//  result   | empty / pop        | status, channel_index, channel_value,
//           |                    | failsafe, link_lost, ch17/ch18_flag, last
//  config   | wr_en (no wait)    | wr_index, wr_data
//
// one item accepted per cycle while full is low; a byte that finishes a frame
// or a timeout queues one job in the two-entry job queue
// the back part gives one result per cycle while pop keeps up: sixteen for a
// good frame, one for error or desync; the result register sets this pace
// full rises only when both job slots are taken, so bytes keep flowing while
// results of the previous frame still wait to be popped
// rst is synchronous and active high: empties queue and result register,
// clears the byte count and restores header_byte 0x0F and end_byte 0x00
module sbus_frame_decoder_top
  import sbfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input queue side
  input  logic                 push,
  output logic                 full,
  input  logic                 command,
  input  logic [7:0]           data_byte,
  // register writes
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status,
  output logic [CH_IDX_W-1:0]  channel_index,
  output logic [CH_W-1:0]      channel_value,
  output logic                 failsafe,
  output logic                 link_lost,
  output logic                 ch17_flag,
  output logic                 ch18_flag,
  output logic                 last
);

  q_ctrl_t qs;
  logic    job_push;
  logic    job_pop;
  job_t    job;
  job_t    head;

  assign full = qs.full;

  // front: collects bytes, checks header and end byte, builds jobs
  sbfd_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .command   (command),
    .data_byte (data_byte),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .qs        (qs),
    .job_push  (job_push),
    .job       (job)
  );

  // holds a snapshot of each finished frame so the shift line can refill
  sbfd_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .job_push (job_push),
    .job_in   (job),
    .job_pop  (job_pop),
    .qs       (qs),
    .head     (head)
  );

  // back: walks the channels of the head job into the result register
  sbfd_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .qs            (qs),
    .head          (head),
    .job_pop       (job_pop),
    .pop           (pop),
    .empty         (empty),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .failsafe      (failsafe),
    .link_lost     (link_lost),
    .ch17_flag     (ch17_flag),
    .ch18_flag     (ch18_flag),
    .last          (last)
  );

endmodule

// ----- sv/sbfd_checker.sv -----
// port-level checker for the sbus frame decoder, bound to the top level
`include "sbus_frame_decoder_top_macros.svh"

module sbfd_checker
  import sbfd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input logic [1:0]          status,
  input logic [CH_IDX_W-1:0] channel_index,
  input logic [CH_W-1:0]     channel_value,
  input logic                last
);

  // nothing waits on the result side right after reset
  `SBFD_ASSERT_RST(a_empty_after_rst, rst, empty)
  // a waiting result that is not taken stays put
  `SBFD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(channel_value) && $stable(status))
  // error and desync results are single items
  `SBFD_ASSERT_NOW(a_err_last, !empty && status != ST_CHANNEL, last && channel_index == '0)
  // a good frame ends exactly at channel 15
  `SBFD_ASSERT_NOW(a_ch_last, !empty && status == ST_CHANNEL, last == (channel_index == CH_IDX_W'(NUM_CH - 1)))
  // no status code beyond desync
  `SBFD_ASSERT_NOW(a_status, !empty, status == ST_CHANNEL || status == ST_ERROR || status == ST_DESYNC)

endmodule

bind sbus_frame_decoder_top sbfd_checker u_sbfd_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .status        (status),
  .channel_index (channel_index),
  .channel_value (channel_value),
  .last          (last)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for the sbus frame decoder: directed and random uart byte streams
`timescale 1ns / 100ps

module tb_top;
  import sbfd_pkg::*;

  // one item on the input side: a received byte or an idle timeout
  typedef struct packed {
    logic       timeout;
    logic [7:0] data;
  } uart_item_t;

  // one decoded result as the block should present it
  typedef struct packed {
    status_t               status;
    logic [CH_IDX_W-1:0]   idx;
    logic [CH_W-1:0]       value;
    logic                  failsafe;
    logic                  link_lost;
    logic                  ch17;
    logic                  ch18;
    logic                  last;
  } sbus_result_t;

  // clock, reset and every input start at known values
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 command   = 1'b0;
  logic [7:0]           data_byte = 8'h00;
  logic                 wr_en     = 1'b0;
  logic [REG_IDX_W-1:0] wr_index  = REG_HEADER;
  logic [REG_W-1:0]     wr_data   = '0;
  logic                 pop       = 1'b0;

  logic                 full;
  logic                 empty;
  logic [1:0]           status;
  logic [CH_IDX_W-1:0]  channel_index;
  logic [CH_W-1:0]      channel_value;
  logic                 failsafe;
  logic                 link_lost;
  logic                 ch17_flag;
  logic                 ch18_flag;
  logic                 last;

  sbus_frame_decoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .data_byte     (data_byte),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .failsafe      (failsafe),
    .link_lost     (link_lost),
    .ch17_flag     (ch17_flag),
    .ch18_flag     (ch18_flag),
    .last          (last)
  );

  always #5 clk = ~clk;

  // items waiting to be driven, and results the decoder still owes us
  uart_item_t   byte_stream[$];
  sbus_result_t due_results[$];

  // our own copy of the decoder state and its two registers
  logic [7:0]         hdr_cfg = 8'h0F;
  logic [7:0]         end_cfg = 8'h00;
  logic [COUNT_W-1:0] frame_count;
  logic [7:0]         frame_bytes [FRAME_STORED];

  // generator side: byte count as it will be once everything queued is taken
  int gen_count = 0;

  int mismatches    = 0;
  int items_taken   = 0;
  int good_channels = 0;
  int frame_errors  = 0;
  int desyncs       = 0;

  // sender burst shaping and receiver stall pattern
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;

  // ---------------------------------------------------------------------------
  // predictor: runs once per accepted item, appends what the decoder must emit
  // ---------------------------------------------------------------------------
  task automatic sbus_decode(input uart_item_t it);
    sbus_result_t r;
    int           bitpos;
    int           b;
    logic [23:0]  w;
    logic [7:0]   flags;
    r = '0;
    if (it.timeout) begin
      // desync: byte count restarts, flags read as failsafe and link lost
      frame_count = '0;
      r.status = ST_DESYNC;
      r.failsafe = 1'b1;
      r.link_lost = 1'b1;
      r.last = 1'b1;
      due_results.push_back(r);
    end else if (frame_count < FRAME_STORED) begin
      frame_bytes[frame_count] = it.data;
      frame_count = frame_count + 1'b1;
    end else begin
      // 25th byte closes the frame whatever the check says
      frame_count = '0;
      if (frame_bytes[0] != hdr_cfg || it.data != end_cfg) begin
        r.status = ST_ERROR;
        r.failsafe = 1'b1;
        r.link_lost = 1'b1;
        r.last = 1'b1;
        due_results.push_back(r);
      end else begin
        flags = frame_bytes[FRAME_STORED-1];
        for (int i = 0; i < NUM_CH; i++) begin
          // channel i sits at payload bits 11i..11i+10, lsb first
          bitpos = CH_W * i;
          b = 1 + bitpos / 8;
          w = {frame_bytes[b+2], frame_bytes[b+1], frame_bytes[b]};
          r.status = ST_CHANNEL;
          r.idx = i[CH_IDX_W-1:0];
          r.value = CH_W'(w >> (bitpos % 8));
          r.failsafe = flags[3];
          r.link_lost = flags[2];
          r.ch17 = flags[0];
          r.ch18 = flags[1];
          r.last = (i == NUM_CH - 1);
          due_results.push_back(r);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps, occasional long unbroken runs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      frame_count = '0;
      burst_left = $urandom_range(1, 30);
      gap_left = 0;
    end else begin
      if (push && !full) begin
        sbus_decode('{timeout: command, data: data_byte});
        items_taken++;
      end
      if (push && full) begin
        // held: same item stays on the ports until the block takes it
      end else if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
        command <= 1'($urandom);
        data_byte <= 8'($urandom);
      end else if (byte_stream.size() != 0) begin
        push <= 1'b1;
        command <= byte_stream[0].timeout;
        data_byte <= byte_stream[0].data;
        void'(byte_stream.pop_front());
        if (burst_left <= 1) begin
          if ($urandom_range(0, 5) == 0) begin
            // no idling for a long stretch
            burst_left = $urandom_range(60, 120);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each popped result with the oldest one due
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    sbus_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d index %0d value %0d",
               $time, status, channel_index, channel_value);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      report_field("status", want.status, status);
      report_field("channel_index", want.idx, channel_index);
      report_field("channel_value", want.value, channel_value);
      report_field("failsafe", want.failsafe, failsafe);
      report_field("link_lost", want.link_lost, link_lost);
      report_field("ch17_flag", want.ch17, ch17_flag);
      report_field("ch18_flag", want.ch18, ch18_flag);
      report_field("last", want.last, last);
      case (want.status)
        ST_CHANNEL: good_channels++;
        ST_ERROR:   frame_errors++;
        default:    desyncs++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (pop && !empty) check_result();
      // stall pattern: modes of random length, from always ready to long stalls
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom);
        2:       pop <= (stall_left % 3 == 0);
        default: pop <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic tmo, input logic [7:0] d);
    byte_stream.push_back('{timeout: tmo, data: d});
    if (tmo) gen_count = 0;
    else if (gen_count < FRAME_STORED) gen_count++;
    else gen_count = 0;
  endtask

  // a whole 25-byte frame; payload style 0 random, 1 all zero, 2 all ones
  task automatic queue_frame(input logic [7:0] hdr, input logic [7:0] tail, input int style);
    if (gen_count != 0) queue_item(1'b1, 8'($urandom));
    queue_item(1'b0, hdr);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case (style)
        1:       queue_item(1'b0, 8'h00);
        2:       queue_item(1'b0, 8'hFF);
        default: queue_item(1'b0, 8'($urandom));
      endcase
    end
    queue_item(1'b0, 8'($urandom));
    queue_item(1'b0, tail);
  endtask

  // half well-formed frames, mostly with random content, the rest broken or noise
  task automatic queue_random(input int budget);
    int start;
    int pick;
    int n;
    start = byte_stream.size();
    while (byte_stream.size() - start < budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        queue_frame(hdr_cfg, end_cfg, (pick == 0) ? 1 : (pick == 1) ? 2 : 0);
      end else if (pick < 12) begin
        queue_frame(hdr_cfg ^ 8'($urandom_range(1, 255)), end_cfg, 0);
      end else if (pick < 14) begin
        queue_frame(hdr_cfg, end_cfg ^ 8'($urandom_range(1, 255)), 0);
      end else if (pick < 17) begin
        // frame cut short by an idle timeout
        if (gen_count != 0) queue_item(1'b1, 8'($urandom));
        n = $urandom_range(0, FRAME_STORED);
        if (n != 0) queue_item(1'b0, hdr_cfg);
        for (int i = 1; i < n; i++) queue_item(1'b0, 8'($urandom));
        queue_item(1'b1, 8'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) queue_item($urandom_range(0, 4) == 0, 8'($urandom));
      end
    end
  endtask

  // wait until every queued item is taken and every due result has arrived,
  // then give the block time to settle bytes that cause no result
  task automatic wait_drained();
    @(negedge clk);
    while (byte_stream.size() != 0 || push || due_results.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_HEADER: hdr_cfg = val;
      default:    end_cfg = val;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // test sequence: directed items, then random phases over several settings
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // timeout with nothing collected, timeout mid-frame, then a good frame at
    // reset settings: channels 0-7 all zero, 8-15 all ones, every flag set
    queue_item(1'b1, 8'h00);
    queue_item(1'b0, 8'h0F);
    queue_item(1'b0, 8'hFF);
    queue_item(1'b1, 8'hFF);
    queue_item(1'b0, 8'h0F);
    for (int i = 0; i < PAYLOAD_BYTES; i++) queue_item(1'b0, (i < 11) ? 8'h00 : 8'hFF);
    queue_item(1'b0, 8'h0F);
    queue_item(1'b0, 8'h00);
    queue_random(28);
    wait_drained();

    // register extremes, both high
    write_reg(REG_HEADER, 8'hFF);
    write_reg(REG_END, 8'hFF);
    @(negedge clk);
    queue_random(28);
    wait_drained();

    // both low
    write_reg(REG_HEADER, 8'h00);
    write_reg(REG_END, 8'h00);
    @(negedge clk);
    queue_random(28);
    wait_drained();

    // arbitrary values
    write_reg(REG_HEADER, 8'($urandom));
    write_reg(REG_END, 8'($urandom));
    @(negedge clk);
    queue_random(28);
    wait_drained();

    // back to the usual frame marks
    write_reg(REG_END, 8'h00);
    write_reg(REG_HEADER, 8'h0F);
    @(negedge clk);
    queue_random(28);
    wait_drained();
    repeat (60) @(posedge clk);

    mismatches += due_results.size();
    $display("tb_top: %0d items in, %0d good channels, %0d frame errors, %0d desyncs",
             items_taken, good_channels, frame_errors, desyncs);
    $display("tb_top: five header/end settings, bursty sender, stalling receiver");
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
